// File: rtl/qph_pkg.sv
// ----------------------------------------------------------------------------
// qph_pkg
// Shared widths, status codes and types for the quadratic probe hash insert.
// ----------------------------------------------------------------------------
package qph_pkg;

  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned ROUND_W  = 10;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned SIZE_MAX  = (1 << SIZE_W) - 1;
  localparam int unsigned SIZE_RSTV = 1024;

  // quotient bits per step of the modulo unit
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned DIV_STEPS = KEY_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [STATUS_W-1:0] STATUS_HOME   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PROBED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: rtl/qph_div.sv
// ----------------------------------------------------------------------------
// qph_div
// Iterative unsigned modulo, DIV_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
module qph_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [qph_pkg::KEY_W-1:0]  dividend_i,
  input  logic [qph_pkg::SIZE_W-1:0] divisor_i,
  output qph_pkg::div_rsp_t         rsp_o
);
  import qph_pkg::*;

  logic [KEY_W-1:0]     dvd_q, dvd_d;
  logic [SIZE_W-1:0]    rem_q, rem_d;
  logic [SIZE_W-1:0]    dsr_q, dsr_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  always_comb begin
    logic [SIZE_W:0] r;
    r      = '0;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      r = {1'b0, rem_q};
      for (int b = 0; b < int'(DIV_BITS); b++) begin
        r = {r[SIZE_W-1:0], dvd_q[KEY_W-1-b]};
        if (r >= {1'b0, dsr_q}) begin
          r = r - {1'b0, dsr_q};
        end
      end
      rem_d = r[SIZE_W-1:0];
      dvd_d = dvd_q << DIV_BITS;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// File: rtl/qph_mem.sv
// ----------------------------------------------------------------------------
// qph_mem
// Slot store: occupied bits with two registered read ports, key values.
// ----------------------------------------------------------------------------
module qph_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic                     wocc_i,
  input  logic [qph_pkg::KEY_W-1:0] wkey_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_a_i,
  input  logic [AW-1:0]            raddr_b_i,
  output logic                     rocc_a_o,
  output logic                     rocc_b_o
);
  import qph_pkg::*;

  logic             occ_mem [DEPTH];
  logic [KEY_W-1:0] key_mem [DEPTH];
  logic             rocc_a_q, rocc_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      occ_mem[waddr_i] <= wocc_i;
    end
    if (we_i && wocc_i) begin
      key_mem[waddr_i] <= wkey_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rocc_a_q <= occ_mem[raddr_a_i];
      rocc_b_q <= occ_mem[raddr_b_i];
    end
  end

  assign rocc_a_o = rocc_a_q;
  assign rocc_b_o = rocc_b_q;

endmodule

// File: rtl/quadratic_probe_hash_insert.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_insert
// Open-addressed hash insert with alternating quadratic probing.
// ----------------------------------------------------------------------------
// One request is handled at a time: the 8-step modulo unit runs, then
//   one read/check pair of the slot memory per probe round, and the check
//   waits while a held result is stalled at the output.
// Reset: occupied bits are swept clear slot by slot; no request
//   is taken during the sweep. Table size resets to 1024 (capped at depth).
module quadratic_probe_hash_insert #(
  parameter int unsigned TABLE_DEPTH      = 1024,
  parameter int unsigned MAX_PROBE_ROUNDS = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          table_size_we_i,
  input  logic [qph_pkg::SIZE_W-1:0]     table_size_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [qph_pkg::KEY_W-1:0] key_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [qph_pkg::SLOT_W-1:0]     slot_index_o,
  output logic [qph_pkg::ROUND_W-1:0]    probe_round_o,
  output logic [qph_pkg::STATUS_W-1:0]   insert_status_o
);
  import qph_pkg::*;

  localparam int unsigned AW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned RW       = $clog2(MAX_PROBE_ROUNDS + 1);
  localparam int unsigned SIZE_CAP = (TABLE_DEPTH > SIZE_MAX) ? SIZE_MAX : TABLE_DEPTH;
  localparam int unsigned SIZE_RST = (SIZE_RSTV > TABLE_DEPTH) ? TABLE_DEPTH : SIZE_RSTV;

  localparam int unsigned ST_W    = 3;
  localparam logic [ST_W-1:0] ST_CLR  = 3'd0;
  localparam logic [ST_W-1:0] ST_IDLE = 3'd1;
  localparam logic [ST_W-1:0] ST_DIV  = 3'd2;
  localparam logic [ST_W-1:0] ST_FIN  = 3'd3;
  localparam logic [ST_W-1:0] ST_RD   = 3'd4;
  localparam logic [ST_W-1:0] ST_CHK  = 3'd5;

  logic [ST_W-1:0]   state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic              neg_q, neg_d;
  logic [SIZE_W-1:0] home_q, home_d;
  logic [SIZE_W-1:0] sq_q, sq_d;
  logic [SIZE_W-1:0] odd_q, odd_d;
  logic [RW-1:0]     round_q, round_d;
  logic [SIZE_W-1:0] up_q, up_d;
  logic [SIZE_W-1:0] down_q, down_d;

  logic                out_valid_q, out_valid_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [ROUND_W-1:0]  oround_q, oround_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic              in_take;
  logic              div_start;
  logic [KEY_W-1:0]  key_mag;
  div_rsp_t          div_rsp;
  logic              size_one;
  logic              out_free;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic              mem_wocc;
  logic              mem_re;
  logic              occ_a, occ_b;

  logic [SIZE_W:0]   up_sum, down_sum, sq_sum, odd_sum;
  logic [SIZE_W-1:0] sq_next, odd_next;

  // configuration, clamped to 1..min(TABLE_DEPTH, SIZE_MAX)
  always_comb begin
    size_d = size_q;
    if (table_size_we_i) begin
      if (table_size_i == '0) begin
        size_d = SIZE_W'(1);
      end else if (32'(table_size_i) > 32'(SIZE_CAP)) begin
        size_d = SIZE_W'(SIZE_CAP);
      end else begin
        size_d = table_size_i;
      end
    end
  end

  assign size_one  = (size_q == SIZE_W'(1));
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take   = in_valid_i && !in_stall_o;
  assign div_start = in_take;
  assign key_mag   = key_value_i[KEY_W-1] ? (~key_value_i + 1'b1) : key_value_i;
  assign out_free  = !out_valid_q || !out_stall_i;

  qph_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (key_mag),
    .divisor_i  (size_q),
    .rsp_o      (div_rsp)
  );

  // probe addresses from the current square
  always_comb begin
    up_sum = {1'b0, home_q} + {1'b0, sq_q};
    up_d   = (up_sum >= {1'b0, size_q}) ? SIZE_W'(up_sum - {1'b0, size_q})
                                        : up_sum[SIZE_W-1:0];
    down_sum = (home_q >= sq_q) ? ({1'b0, home_q} - {1'b0, sq_q})
                                : ({1'b0, home_q} + {1'b0, size_q} - {1'b0, sq_q});
    down_d = down_sum[SIZE_W-1:0];
  end

  // next square via running odd term
  always_comb begin
    sq_sum   = {1'b0, sq_q} + {1'b0, odd_q};
    sq_next  = (sq_sum >= {1'b0, size_q}) ? SIZE_W'(sq_sum - {1'b0, size_q})
                                          : sq_sum[SIZE_W-1:0];
    odd_sum  = {1'b0, odd_q} + (SIZE_W + 1)'(2);
    odd_next = size_one ? '0
             : (odd_sum >= {1'b0, size_q}) ? SIZE_W'(odd_sum - {1'b0, size_q})
                                           : odd_sum[SIZE_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    key_d       = key_q;
    neg_d       = neg_q;
    home_d      = home_q;
    sq_d        = sq_q;
    odd_d       = odd_q;
    round_d     = round_q;
    out_valid_d = out_valid_q && out_stall_i;
    slot_d      = slot_q;
    oround_d    = oround_q;
    status_d    = status_q;
    mem_we      = 1'b0;
    mem_waddr   = AW'(up_q);
    mem_wocc    = 1'b1;
    mem_re      = 1'b0;

    unique case (state_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wocc  = 1'b0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_take) begin
          key_d   = key_value_i;
          neg_d   = key_value_i[KEY_W-1];
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (neg_q && (div_rsp.rem != '0)) begin
          home_d = size_q - div_rsp.rem;
        end else if (neg_q) begin
          home_d = '0;
        end else begin
          home_d = div_rsp.rem;
        end
        sq_d    = '0;
        odd_d   = size_one ? '0 : SIZE_W'(1);
        round_d = '0;
        state_d = ST_RD;
      end
      ST_RD: begin
        mem_re  = 1'b1;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (out_free) begin
          priority if (!occ_a) begin
            mem_we      = 1'b1;
            mem_waddr   = AW'(up_q);
            out_valid_d = 1'b1;
            slot_d      = SLOT_W'(up_q);
            oround_d    = ROUND_W'(round_q);
            status_d    = (round_q == '0) ? STATUS_HOME : STATUS_PROBED;
            state_d     = ST_IDLE;
          end else if (!occ_b && (round_q != '0)) begin
            mem_we      = 1'b1;
            mem_waddr   = AW'(down_q);
            out_valid_d = 1'b1;
            slot_d      = SLOT_W'(down_q);
            oround_d    = ROUND_W'(round_q);
            status_d    = STATUS_PROBED;
            state_d     = ST_IDLE;
          end else if (round_q == RW'(MAX_PROBE_ROUNDS)) begin
            out_valid_d = 1'b1;
            slot_d      = '0;
            oround_d    = '0;
            status_d    = STATUS_FULL;
            state_d     = ST_IDLE;
          end else begin
            sq_d    = sq_next;
            odd_d   = odd_next;
            round_d = round_q + 1'b1;
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  qph_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wocc_i    (mem_wocc),
    .wkey_i    (key_q),
    .re_i      (mem_re),
    .raddr_a_i (AW'(up_d)),
    .raddr_b_i (AW'(down_d)),
    .rocc_a_o  (occ_a),
    .rocc_b_o  (occ_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      size_q      <= SIZE_W'(SIZE_RST);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      size_q      <= size_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    neg_q    <= neg_d;
    home_q   <= home_d;
    sq_q     <= sq_d;
    odd_q    <= odd_d;
    round_q  <= round_d;
    slot_q   <= slot_d;
    oround_q <= oround_d;
    status_q <= status_d;
    if (state_q == ST_RD) begin
      up_q   <= up_d;
      down_q <= down_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign slot_index_o    = slot_q;
  assign probe_round_o   = oround_q;
  assign insert_status_o = status_q;

endmodule

// File: rtl/qph_chk.sv
// ----------------------------------------------------------------------------
// qph_chk
// Port-level checks on the insert results, bound to the top level.
// ----------------------------------------------------------------------------
module qph_chk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [qph_pkg::SLOT_W-1:0]     slot_index_i,
  input  logic [qph_pkg::ROUND_W-1:0]    probe_round_i,
  input  logic [qph_pkg::STATUS_W-1:0]   insert_status_i
);
  import qph_pkg::*;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (insert_status_i == STATUS_HOME || insert_status_i == STATUS_PROBED ||
                     insert_status_i == STATUS_FULL))
    else $error("invalid insert status");

  a_home_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && insert_status_i == STATUS_HOME) |-> (probe_round_i == '0))
    else $error("home insert with non-zero round");

  a_probed_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && insert_status_i == STATUS_PROBED) |-> (probe_round_i != '0))
    else $error("probed insert with zero round");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && insert_status_i == STATUS_FULL) |->
      (slot_index_i == '0 && probe_round_i == '0))
    else $error("full result carries slot or round");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=> (out_valid_i && $stable(slot_index_i) &&
      $stable(probe_round_i) && $stable(insert_status_i)))
    else $error("stalled result changed");

endmodule

bind quadratic_probe_hash_insert qph_chk u_qph_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .slot_index_i    (slot_index_o),
  .probe_round_i   (probe_round_o),
  .insert_status_i (insert_status_o)
);
